/* rtl/core/nps_pkg.sv */
// Shared types and constants of the non-preemptive priority scheduler core.
package nps_pkg;

  localparam int ARR_W      = 16;
  localparam int BUR_W      = 16;
  localparam int PRI_W      = 8;
  localparam int TIME_W     = 22;
  localparam int SUM_W      = 27;
  localparam int PNUM_W     = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 152;

  localparam logic [TIME_W-1:0] T_MAX   = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};

  // One process descriptor as it sits in the descriptor store.
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [BUR_W-1:0] burst;
    logic [ARR_W-1:0] arr;
  } desc_t;

  // Queue entry: a descriptor plus the mark that it closes the current set.
  typedef struct packed {
    desc_t desc;
    logic  close;
  } qent_t;

  // Per-process result kept by the scheduler.
  typedef struct packed {
    logic [TIME_W-1:0] comp;
    logic [TIME_W-1:0] resp;
  } res_t;

  // One report row.
  typedef struct packed {
    logic [SUM_W-1:0]  tot_tat;
    logic [SUM_W-1:0]  tot_wait;
    logic [TIME_W-1:0] resp;
    logic [TIME_W-1:0] wait_t;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] comp;
    logic [PNUM_W-1:0] pnum;
  } row_t;

endpackage

/* rtl/core/nps_front.sv */
// Input side: takes descriptor transactions and marks the one that closes a set.
module nps_front #(
  parameter int MAX_PROCESSES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nps_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  input  logic                            q_full,
  output logic                            q_push,
  output nps_pkg::qent_t                  q_push_ent
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_PROCESSES - 1);

  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             close;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // A set closes on the flagged descriptor or when the store becomes full.
  assign close = in_tlast || (slot_r == LAST_SLOT);

  assign q_push_ent.desc.arr   = in_tdata[15:0];
  assign q_push_ent.desc.burst = in_tdata[31:16];
  assign q_push_ent.desc.pri   = in_tdata[39:32];
  assign q_push_ent.close      = close;

  always_comb begin
    slot_nxt = slot_r;
    if (q_push) begin
      slot_nxt = close ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

/* rtl/core/nps_queue.sv */
// Two-entry queue that decouples the input side from the scheduler.
module nps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nps_pkg::qent_t push_ent,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output nps_pkg::qent_t head
);

  nps_pkg::qent_t mem_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/nps_back.sv */
// Scheduler side: descriptor store, selection scan, result store and row report.
module nps_back #(
  parameter int MAX_PROCESSES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  nps_pkg::qent_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output nps_pkg::row_t  out_row,
  output logic           out_final
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN, ST_DECIDE, ST_EMIT_RD, ST_EMIT_CALC, ST_EMIT_HOLD
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           left_r, left_nxt;
  logic [CNT_W-1:0]           scan_r, scan_nxt;
  logic [nps_pkg::TIME_W-1:0] ct_r, ct_nxt;
  logic                       pv_r, pv_nxt;
  logic [IDX_W-1:0]           pidx_r, pidx_nxt;
  logic                       pick_v_r, pick_v_nxt;
  logic [IDX_W-1:0]           pick_idx_r, pick_idx_nxt;
  logic [nps_pkg::PRI_W-1:0]  pick_pri_r, pick_pri_nxt;
  logic [nps_pkg::ARR_W-1:0]  pick_arr_r, pick_arr_nxt;
  logic [nps_pkg::BUR_W-1:0]  pick_bur_r, pick_bur_nxt;
  logic [nps_pkg::ARR_W-1:0]  narr_r, narr_nxt;
  logic [MAX_PROCESSES-1:0]   done_r, done_nxt;
  logic [nps_pkg::SUM_W-1:0]  wsum_r, wsum_nxt;
  logic [nps_pkg::SUM_W-1:0]  tsum_r, tsum_nxt;
  logic [IDX_W-1:0]           emit_r, emit_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_final_r, out_final_nxt;
  nps_pkg::row_t              row_r, row_nxt;

  nps_pkg::desc_t             desc_mem [MAX_PROCESSES];
  nps_pkg::res_t              res_mem  [MAX_PROCESSES];
  nps_pkg::desc_t             desc_q_r;
  nps_pkg::res_t              res_q_r;
  logic [IDX_W-1:0]           rd_addr;
  logic                       res_we;
  nps_pkg::res_t              res_wdata;

  logic [nps_pkg::TIME_W:0]   ct_sum;
  logic [nps_pkg::TIME_W-1:0] ct_run;
  logic [nps_pkg::TIME_W-1:0] arr_ext, bur_ext, tat, wt;
  logic [nps_pkg::SUM_W:0]    wsum_add, tsum_add;
  logic [nps_pkg::SUM_W-1:0]  wsum_new, tsum_new;
  logic                       emit_last;

  assign out_valid = out_valid_r;
  assign out_row   = row_r;
  assign out_final = out_final_r;

  // Finish tick of the picked process, saturated.
  assign ct_sum = {1'b0, ct_r} + (nps_pkg::TIME_W + 1)'(pick_bur_r);
  assign ct_run = (ct_sum > {1'b0, nps_pkg::T_MAX}) ? nps_pkg::T_MAX
                                                    : ct_sum[nps_pkg::TIME_W-1:0];

  // Row arithmetic from the registered store reads.
  assign arr_ext  = nps_pkg::TIME_W'(desc_q_r.arr);
  assign bur_ext  = nps_pkg::TIME_W'(desc_q_r.burst);
  assign tat      = res_q_r.comp - arr_ext;
  assign wt       = (tat >= bur_ext) ? (tat - bur_ext) : '0;
  assign wsum_add = {1'b0, wsum_r} + (nps_pkg::SUM_W + 1)'(wt);
  assign tsum_add = {1'b0, tsum_r} + (nps_pkg::SUM_W + 1)'(tat);
  assign wsum_new = wsum_add[nps_pkg::SUM_W] ? nps_pkg::SUM_MAX
                                             : wsum_add[nps_pkg::SUM_W-1:0];
  assign tsum_new = tsum_add[nps_pkg::SUM_W] ? nps_pkg::SUM_MAX
                                             : tsum_add[nps_pkg::SUM_W-1:0];
  assign emit_last = ((CNT_W'(emit_r) + 1'b1) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    scan_nxt      = scan_r;
    ct_nxt        = ct_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    pick_v_nxt    = pick_v_r;
    pick_idx_nxt  = pick_idx_r;
    pick_pri_nxt  = pick_pri_r;
    pick_arr_nxt  = pick_arr_r;
    pick_bur_nxt  = pick_bur_r;
    narr_nxt      = narr_r;
    done_nxt      = done_r;
    wsum_nxt      = wsum_r;
    tsum_nxt      = tsum_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_final_nxt = out_final_r;
    row_nxt       = row_r;
    q_pop         = 1'b0;
    res_we        = 1'b0;
    res_wdata     = '0;
    rd_addr       = emit_r;

    unique case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (q_head.close) begin
            ct_nxt     = '0;
            left_nxt   = cnt_r + 1'b1;
            scan_nxt   = '0;
            pv_nxt     = 1'b0;
            pick_v_nxt = 1'b0;
            narr_nxt   = '1;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        rd_addr = scan_r[IDX_W-1:0];
        if (scan_r < cnt_r) begin
          scan_nxt = scan_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = scan_r[IDX_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        // Evaluate the entry read last cycle; ascending order keeps the lower
        // index on a full tie.
        if (pv_r && !done_r[pidx_r]) begin
          if (nps_pkg::TIME_W'(desc_q_r.arr) > ct_r) begin
            if (desc_q_r.arr < narr_r) begin
              narr_nxt = desc_q_r.arr;
            end
          end else if (!pick_v_r || (desc_q_r.pri < pick_pri_r) ||
                       ((desc_q_r.pri == pick_pri_r) && (desc_q_r.arr < pick_arr_r))) begin
            pick_v_nxt   = 1'b1;
            pick_idx_nxt = pidx_r;
            pick_pri_nxt = desc_q_r.pri;
            pick_arr_nxt = desc_q_r.arr;
            pick_bur_nxt = desc_q_r.burst;
          end
        end
        if ((scan_r == cnt_r) && !pv_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        scan_nxt   = '0;
        pv_nxt     = 1'b0;
        pick_v_nxt = 1'b0;
        narr_nxt   = '1;
        state_nxt  = ST_SCAN;
        if (pick_v_r) begin
          res_we                 = 1'b1;
          res_wdata.comp         = ct_run;
          res_wdata.resp         = ct_r - nps_pkg::TIME_W'(pick_arr_r);
          done_nxt[pick_idx_r]   = 1'b1;
          ct_nxt                 = ct_run;
          left_nxt               = left_r - 1'b1;
          if (left_r == CNT_W'(1)) begin
            emit_nxt  = '0;
            wsum_nxt  = '0;
            tsum_nxt  = '0;
            state_nxt = ST_EMIT_RD;
          end
        end else begin
          // Nothing has arrived: jump to the earliest pending arrival.
          ct_nxt = nps_pkg::TIME_W'(narr_r);
        end
      end

      ST_EMIT_RD: begin
        rd_addr   = emit_r;
        state_nxt = ST_EMIT_CALC;
      end

      ST_EMIT_CALC: begin
        wsum_nxt         = wsum_new;
        tsum_nxt         = tsum_new;
        row_nxt.pnum     = nps_pkg::PNUM_W'(emit_r) + 1'b1;
        row_nxt.comp     = res_q_r.comp;
        row_nxt.tat      = tat;
        row_nxt.wait_t   = wt;
        row_nxt.resp     = res_q_r.resp;
        row_nxt.tot_wait = emit_last ? wsum_new : '0;
        row_nxt.tot_tat  = emit_last ? tsum_new : '0;
        out_final_nxt    = emit_last;
        out_valid_nxt    = 1'b1;
        state_nxt        = ST_EMIT_HOLD;
      end

      ST_EMIT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            cnt_nxt   = '0;
            done_nxt  = '0;
            state_nxt = ST_LOAD;
          end else begin
            emit_nxt  = emit_r + 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_mem[cnt_r[IDX_W-1:0]] <= q_head.desc;
    end
    desc_q_r <= desc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[pick_idx_r] <= res_wdata;
    end
    res_q_r <= res_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      left_r      <= '0;
      scan_r      <= '0;
      ct_r        <= '0;
      pv_r        <= 1'b0;
      pick_v_r    <= 1'b0;
      narr_r      <= '1;
      done_r      <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
      out_final_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      scan_r      <= scan_nxt;
      ct_r        <= ct_nxt;
      pv_r        <= pv_nxt;
      pick_v_r    <= pick_v_nxt;
      narr_r      <= narr_nxt;
      done_r      <= done_nxt;
      wsum_r      <= wsum_nxt;
      tsum_r      <= tsum_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      out_final_r <= out_final_nxt;
    end
    pidx_r     <= pidx_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_pri_r <= pick_pri_nxt;
    pick_arr_r <= pick_arr_nxt;
    pick_bur_r <= pick_bur_nxt;
    row_r      <= row_nxt;
  end

endmodule

/* rtl/core/nonpreemptive_priority_scheduler_core.sv */
// Top level of the non-preemptive priority scheduler core.
//
// Usage: process descriptors arrive on the in_ stream, one transaction each,
// carrying arrival tick, burst length and priority number; in_tlast marks the
// final descriptor of a set, and a set also closes when MAX_PROCESSES
// descriptors have been loaded. The core then schedules the set without
// preemption from tick 0 and sends one row per process, in load order, on
// the out_ stream; out_tlast marks the last row, which alone carries the
// waiting and turnaround totals.
// Throughput: descriptors load at one per cycle through a two-entry queue
// while in_tready is high. Once a set closes, each scheduling decision scans
// the store at one entry per cycle; a set of n processes needs at most 2n
// decisions (idle gaps add a jump each). Each row is then read through the
// single read port of the stores and computed into the output register,
// where it waits through any receiver stall. While the set is scheduled and
// reported, in_tready drops once the queue holds two entries.
// Reset clears the queue, the load count, the done flags and the output
// valid; no clearing pass is needed. A stalled receiver simply holds the
// current row in the output register until it is taken.
module nonpreemptive_priority_scheduler_core #(
  parameter int MAX_PROCESSES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: arrival_time[15:0], burst_time[31:16], priority_req[39:32]
  input  logic [39:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: process_number[5:0], completion_time[27:6],
  // turnaround_time[49:28], waiting_time[71:50], response_time[93:72],
  // total_waiting[120:94], total_turnaround[147:121], zero pad [151:148]
  output logic [151:0] out_tdata,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready
);

  logic           q_push, q_full, q_valid, q_pop;
  nps_pkg::qent_t q_push_ent, q_head;
  nps_pkg::row_t  row;

  nps_front #(.MAX_PROCESSES(MAX_PROCESSES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_ent (q_push_ent)
  );

  nps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_push_ent),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (q_head)
  );

  nps_back #(.MAX_PROCESSES(MAX_PROCESSES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (row),
    .out_final (out_tlast)
  );

  // Row fields packed from the lowest bit up, padded to whole bytes.
  assign out_tdata = {4'b0000, row.tot_tat, row.tot_wait, row.resp, row.wait_t,
                      row.tat, row.comp, row.pnum};

  // The scheduler never takes a queue entry that is not there.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // No descriptor is loaded while a report row is pending.
  a_no_load_while_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !q_pop)
    else $error("descriptor loaded during report");

  // Totals are zero on every row except the last one of a set.
  a_totals_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[147:94] == '0))
    else $error("totals present on a row before the last");

  // A row has a process number from one upward.
  a_pnum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] != 6'd0))
    else $error("zero process number in report row");

endmodule
